// File: hdl/fcr_pkg.sv
// Shared types and constants of the framed command receiver.
// Holds the result record, status, operation and register-index codes.
// No dependencies; every other file imports this package.
package fcr_pkg;

  localparam int DEF_CHANNELS    = 3;
  localparam int DEF_PAYLOAD_MAX = 32;

  localparam int CHAN_W = 2;
  localparam int IDX_W  = 5;

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic CFG_EXPECTED_ID = 1'b0;
  localparam logic CFG_TIMEOUT     = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAN_W-1:0] chan;
    logic [7:0]        command;
    logic [7:0]        id;
    logic [7:0]        size;
    logic [15:0]       check;
    logic [7:0]        pbyte;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } res_t;

endpackage

// File: hdl/fcr_out_stage.sv
// Result holding register of the framed command receiver.
// Depends on fcr_pkg for the result record.
module fcr_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  fcr_pkg::res_t d,
  input  logic          out_stall,
  output logic          out_valid,
  output logic          free,
  output fcr_pkg::res_t q
);
  import fcr_pkg::*;

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// File: hdl/fcr_parser.sv
// Frame parser: channel-state RAM, payload RAM and the sequencer around them.
// Depends on fcr_pkg for codes and the result record.
module fcr_parser #(
  parameter int CHANNELS    = fcr_pkg::DEF_CHANNELS,
  parameter int PAYLOAD_MAX = fcr_pkg::DEF_PAYLOAD_MAX
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic [fcr_pkg::CHAN_W-1:0] channel,
  input  logic [7:0]                data_byte,
  input  logic [7:0]                expected_id,
  input  logic [15:0]               timeout_ticks,
  input  logic                      out_free,
  output logic                      res_load,
  output fcr_pkg::res_t             res
);
  import fcr_pkg::*;

  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int PDEPTH = CHANNELS * PAYLOAD_MAX;
  localparam int PA_W  = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

  localparam logic [2:0] PH_SYNC   = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_ID     = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CHK_HI = 3'd5;
  localparam logic [2:0] PH_CHK_LO = 3'd6;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_BEVAL   = 3'd1;
  localparam logic [2:0] S_FRM_RD  = 3'd2;
  localparam logic [2:0] S_FRM_OUT = 3'd3;
  localparam logic [2:0] S_TRD     = 3'd4;
  localparam logic [2:0] S_TEVAL   = 3'd5;
  localparam logic [2:0] S_TEND    = 3'd6;

  typedef struct packed {
    logic [2:0]       phase;
    logic [7:0]       command;
    logic [7:0]       id;
    logic [7:0]       length;
    logic [CNT_W-1:0] count;
    logic [15:0]      check;
    logic [15:0]      age;
  } chan_rec_t;

  function automatic res_t rec_res(chan_rec_t r, logic [CH_IW-1:0] ch, logic [1:0] st);
    res_t o;
    o         = '0;
    o.status  = st;
    o.chan    = CHAN_W'(ch);
    o.command = r.command;
    o.id      = r.id;
    o.size    = r.length;
    o.check   = r.check;
    return o;
  endfunction

  // channel-state RAM; an entry never written reads as the reset record
  chan_rec_t        st_mem [CHANNELS];
  logic [CHANNELS-1:0] st_vld;
  chan_rec_t        st_rd_q;
  logic             st_rd_vld;
  logic             st_re;
  logic [CH_IW-1:0] st_raddr;
  logic             st_we;
  chan_rec_t        st_wdata;
  chan_rec_t        rec;

  // payload RAM, PAYLOAD_MAX bytes per channel
  logic [7:0]       pay_mem [PDEPTH];
  logic [7:0]       pay_rd_q;
  logic             pay_re;
  logic [PA_W-1:0]  pay_raddr;
  logic             pay_we;
  logic [PA_W-1:0]  pay_waddr;

  logic [2:0]       state, state_next;
  logic [CH_IW-1:0] ch_q, ch_q_next;
  logic [7:0]       byte_q, byte_q_next;
  logic [CNT_W-1:0] idx, idx_next;
  res_t             pend, pend_next;
  logic             pend_valid, pend_valid_next;
  res_t             frame_res, frame_res_next;

  chan_rec_t        rec_new;
  res_t             byte_res;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      age_inc;
  logic             emit;
  logic             go_frame;
  logic             timed;
  logic             proceed;
  logic             ch_ok;

  assign rec   = st_rd_vld ? st_rd_q : '0;
  assign ch_ok = (32'(channel) < CHANNELS);
  assign in_stall = (state != S_IDLE);
  assign cnt_inc  = rec.count + CNT_W'(1);
  assign age_inc  = (rec.age == 16'hFFFF) ? rec.age : rec.age + 16'd1;

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[ch_q] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q   <= st_mem[st_raddr];
      st_rd_vld <= st_vld[st_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (st_we) begin
      st_vld[ch_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= byte_q;
    end
    if (pay_re) begin
      pay_rd_q <= pay_mem[pay_raddr];
    end
  end

  assign pay_waddr = PA_W'(ch_q) * PA_W'(PAYLOAD_MAX) + PA_W'(rec.count);
  assign pay_raddr = PA_W'(ch_q) * PA_W'(PAYLOAD_MAX) + PA_W'(idx);

  // record update for one received byte
  always_comb begin
    rec_new  = rec;
    emit     = 1'b0;
    go_frame = 1'b0;
    pay_we   = 1'b0;
    byte_res = '0;
    unique case (rec.phase)
      PH_SYNC: begin
        if (byte_q == SYNC_BYTE) begin
          rec_new       = '0;
          rec_new.phase = PH_CMD;
        end
      end
      PH_CMD: begin
        rec_new.command = byte_q;
        rec_new.phase   = PH_ID;
      end
      PH_ID: begin
        rec_new.id    = byte_q;
        rec_new.phase = PH_LEN;
      end
      PH_LEN: begin
        rec_new.length = byte_q;
        if (byte_q > 8'(PAYLOAD_MAX)) begin
          rec_new.phase = PH_SYNC;
          rec_new.age   = '0;
          emit          = 1'b1;
          byte_res      = rec_res(rec_new, ch_q, ST_OVERSIZE);
        end else if (byte_q == 8'd0) begin
          rec_new.phase = PH_CHK_HI;
        end else begin
          rec_new.phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (rec.count < CNT_W'(PAYLOAD_MAX)) begin
          pay_we        = (state == S_BEVAL);
          rec_new.count = cnt_inc;
        end
        if (8'(rec_new.count) >= rec.length) begin
          rec_new.phase = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        rec_new.check = {byte_q, 8'h00};
        rec_new.phase = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        rec_new.check = rec.check | {8'h00, byte_q};
        rec_new.phase = PH_SYNC;
        rec_new.age   = '0;
        if (rec.id != expected_id) begin
          emit     = 1'b1;
          byte_res = rec_res(rec_new, ch_q, ST_MISMATCH);
        end else if (rec.length == 8'd0) begin
          emit     = 1'b1;
          byte_res = rec_res(rec_new, ch_q, ST_OK);
        end else begin
          go_frame = 1'b1;
        end
        byte_res.last = 1'b1;
      end
      default: begin
        rec_new.phase = PH_SYNC;
      end
    endcase
    if (emit) begin
      byte_res.last = 1'b1;
    end
  end

  // aging of one channel on a tick
  always_comb begin
    timed = 1'b0;
    if ((rec.phase != PH_SYNC) && (age_inc > timeout_ticks)) begin
      timed = 1'b1;
    end
  end

  always_comb begin
    state_next      = state;
    ch_q_next       = ch_q;
    byte_q_next     = byte_q;
    idx_next        = idx;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    frame_res_next  = frame_res;
    st_re           = 1'b0;
    st_raddr        = ch_q;
    st_we           = 1'b0;
    st_wdata        = rec_new;
    pay_re          = 1'b0;
    res_load        = 1'b0;
    proceed         = 1'b0;
    res             = byte_res;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_TICK) begin
            ch_q_next  = '0;
            state_next = S_TRD;
          end else if (ch_ok) begin
            st_re       = 1'b1;
            st_raddr    = CH_IW'(channel);
            ch_q_next   = CH_IW'(channel);
            byte_q_next = data_byte;
            state_next  = S_BEVAL;
          end
        end
      end
      S_BEVAL: begin
        proceed = !emit || out_free;
        if (proceed) begin
          st_we    = 1'b1;
          res_load = emit;
          if (go_frame) begin
            frame_res_next = rec_res(rec_new, ch_q, ST_OK);
            idx_next       = '0;
            state_next     = S_FRM_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FRM_RD: begin
        pay_re     = 1'b1;
        state_next = S_FRM_OUT;
      end
      S_FRM_OUT: begin
        if (out_free) begin
          res_load      = 1'b1;
          res           = frame_res;
          res.pbyte     = pay_rd_q;
          res.idx       = IDX_W'(idx);
          res.last      = ((8'(idx) + 8'd1) == frame_res.size);
          if (res.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + CNT_W'(1);
            state_next = S_FRM_RD;
          end
        end
      end
      S_TRD: begin
        st_re      = 1'b1;
        state_next = S_TEVAL;
      end
      S_TEVAL: begin
        st_wdata = rec;
        if (rec.phase != PH_SYNC) begin
          st_wdata.age = age_inc;
        end
        if (timed) begin
          st_wdata.phase = PH_SYNC;
          st_wdata.age   = '0;
        end
        res     = pend;
        proceed = !timed || !pend_valid || out_free;
        if (proceed) begin
          st_we = 1'b1;
          if (timed) begin
            res_load        = pend_valid;
            pend_next       = rec_res(rec, ch_q, ST_TIMEOUT);
            pend_valid_next = 1'b1;
          end
          if (ch_q == CH_IW'(CHANNELS - 1)) begin
            state_next = S_TEND;
          end else begin
            ch_q_next  = ch_q + CH_IW'(1);
            state_next = S_TRD;
          end
        end
      end
      S_TEND: begin
        res      = pend;
        res.last = 1'b1;
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          res_load        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ch_q      <= ch_q_next;
    byte_q    <= byte_q_next;
    idx       <= idx_next;
    pend      <= pend_next;
    frame_res <= frame_res_next;
  end

endmodule

// File: hdl/framed_command_receiver.sv
// Top level of the framed command receiver: config registers, parser, result register.
// Depends on fcr_pkg, fcr_parser and fcr_out_stage.
//
//   beat      handshake             payload
//   -------   -------------------   ----------------------------------------------
//   input     in_valid / in_stall   operation, channel, data_byte
//   result    out_valid / out_stall status, out_channel, command_code, frame_id,
//                                   payload_size, check_word, payload_byte,
//                                   byte_index, last
//   config    cfg_write             cfg_index, cfg_data
//
// One input beat at a time. A byte beat is accepted, then its record in
// the channel-state RAM is read, modified, written. A completed frame
// then streams its payload with a read and an output step per result,
// set by the payload RAM's registered read port. A tick takes an accept
// step, a read and an evaluate step per channel and a closing step.
// A held result register stalls only the emitting step; a new beat is
// taken while the last result still waits. Reset clears control and the
// channel-record valid bits at once (no clearing pass); the payload RAM
// is not cleared, since a frame only reads bytes it stored itself.
module framed_command_receiver #(
  parameter int CHANNELS    = fcr_pkg::DEF_CHANNELS,
  parameter int PAYLOAD_MAX = fcr_pkg::DEF_PAYLOAD_MAX
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       operation,
  input  logic [fcr_pkg::CHAN_W-1:0] channel,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [fcr_pkg::CHAN_W-1:0] out_channel,
  output logic [7:0]                 command_code,
  output logic [7:0]                 frame_id,
  output logic [7:0]                 payload_size,
  output logic [15:0]                check_word,
  output logic [7:0]                 payload_byte,
  output logic [fcr_pkg::IDX_W-1:0]  byte_index,
  output logic                       last,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_data
);
  import fcr_pkg::*;

  logic [7:0]  expected_id;
  logic [15:0] timeout_ticks;
  logic        res_load;
  logic        out_free;
  res_t        res;
  res_t        res_q;

  // config registers, write only: write only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id   <= 8'd0;
      timeout_ticks <= 16'd1000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID: expected_id   <= cfg_data[7:0];
        CFG_TIMEOUT:     timeout_ticks <= cfg_data;
      endcase
    end
  end

  // parse bytes and ticks against the per-channel records
  fcr_parser #(
    .CHANNELS    (CHANNELS),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .channel       (channel),
    .data_byte     (data_byte),
    .expected_id   (expected_id),
    .timeout_ticks (timeout_ticks),
    .out_free      (out_free),
    .res_load      (res_load),
    .res           (res)
  );

  // hold each result beat until the sink takes it
  fcr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .d         (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (out_free),
    .q         (res_q)
  );

  assign status       = res_q.status;
  assign out_channel  = res_q.chan;
  assign command_code = res_q.command;
  assign frame_id     = res_q.id;
  assign payload_size = res_q.size;
  assign check_word   = res_q.check;
  assign payload_byte = res_q.pbyte;
  assign byte_index   = res_q.idx;
  assign last         = res_q.last;

endmodule
